// File: src/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int NUM_PAGES  = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 32;

  localparam int ACTION_W = 3;
  localparam int PAGE_W   = 17;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;

  localparam int WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W      = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = BIT_W + 1;

  // allocation only reaches pages whose byte address fits in 32 bits
  localparam int ADDR_PAGES  = 1 << (ADDR_W - PAGE_SHIFT);
  localparam int LIMIT_PAGES = (NUM_PAGES < ADDR_PAGES) ? NUM_PAGES : ADDR_PAGES;
  localparam int SCAN_WORDS  = (LIMIT_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int LAST_BITS   = LIMIT_PAGES - (SCAN_WORDS - 1) * WORD_BITS;

  localparam logic [ACTION_W-1:0] ACT_RESERVE_ALL   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE_RANGE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RESERVE_RANGE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ALLOCATE      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FREE_ADDRESS  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECTED     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd3;

  typedef enum logic [1:0] {
    OP_RELEASE,
    OP_RESERVE,
    OP_ALLOC
  } word_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANGE_RD,
    ST_RANGE_WR,
    ST_FIN,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   first_page;
    logic [PAGE_W-1:0]   end_page;
    logic [ADDR_W-1:0]   address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   free_count;
  } out_item_t;

  typedef struct packed {
    word_op_t             op;
    logic [WORD_BITS-1:0] old_word;
    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
  } word_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic [CNT_W-1:0]     cnt;
    logic                 found;
    logic [BIT_W-1:0]     find_bit;
  } word_rsp_t;

endpackage
`default_nettype wire

// File: src/bpa_ram.sv
`default_nettype none
module bpa_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/bpa_word_unit.sv
`default_nettype none
module bpa_word_unit (
  input  wire bpa_pkg::word_req_t req,
  output bpa_pkg::word_rsp_t      rsp
);

  localparam int WB    = bpa_pkg::WORD_BITS;
  localparam int BW    = bpa_pkg::BIT_W;
  localparam int CW    = bpa_pkg::CNT_W;
  localparam int GRP   = 8;
  localparam int NGRP  = (WB + GRP - 1) / GRP;

  logic [WB-1:0] mask;
  logic [WB-1:0] changed;
  logic [WB-1:0] cand;
  logic [WB-1:0] new_word;
  logic          found;
  logic [CW-1:0] grp_cnt;
  logic [CW-1:0] total;
  logic [BW-1:0] first_bit;

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      mask[b] = (BW'(b) >= req.lo) && (BW'(b) <= req.hi);
    end
  end

  always_comb begin
    cand      = ~req.old_word & mask;
    first_bit = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) begin
        first_bit = BW'(b);
      end
    end
  end

  always_comb begin
    found = |cand;
    case (req.op)
      bpa_pkg::OP_RELEASE: begin
        changed  = req.old_word & mask;
        new_word = req.old_word & ~mask;
        found    = |changed;
      end
      bpa_pkg::OP_RESERVE: begin
        changed  = cand;
        new_word = req.old_word | mask;
      end
      bpa_pkg::OP_ALLOC: begin
        changed  = '0;
        new_word = req.old_word | (WB'(1) << first_bit);
      end
      default: begin
        changed  = '0;
        new_word = req.old_word;
      end
    endcase
  end

  // byte-wise population count, then sum of the byte counts
  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_cnt = '0;
      for (int b = 0; b < GRP; b++) begin
        if (g * GRP + b < WB) begin
          grp_cnt = grp_cnt + CW'(changed[g * GRP + b]);
        end
      end
      total = total + grp_cnt;
    end
  end

  always_comb begin
    rsp.new_word = new_word;
    rsp.cnt      = total;
    rsp.found    = found;
    rsp.find_bit = first_bit;
  end

endmodule
`default_nettype wire

// File: src/bitmap_page_allocator_core.sv
// Channel  | Ports               | Handshake
// ---------+---------------------+---------------------------------------------
// input    | start, in_item      | accepted at clk edge with start=1, busy=0
// result   | out_strobe, out_item| valid for exactly one cycle, no back-pressure
//
// One transaction at a time; busy stays high until its result has been strobed.
// Range actions read, then write, each bitmap word touched, then finish and
// respond; allocate streams one word read per cycle until the first free bit
// (up to 2048 words); free reads and writes one word, a rejected one responds
// directly; reserve-all rewrites every word, 2048. After reset the same fill
// runs with busy high. Results go out regardless of the receiver.
`default_nettype none
module bitmap_page_allocator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bpa_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output bpa_pkg::out_item_t      out_item
);

  localparam int IW = bpa_pkg::IDX_W;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int PW = bpa_pkg::PAGE_W;
  localparam int AW = bpa_pkg::ADDR_W;
  localparam int SW = bpa_pkg::STATUS_W;
  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int PS = bpa_pkg::PAGE_SHIFT;

  localparam logic [IW-1:0] LAST_WORD = IW'(bpa_pkg::WORD_COUNT - 1);
  localparam logic [IW-1:0] SCAN_LAST = IW'(bpa_pkg::SCAN_WORDS - 1);
  localparam logic [BW-1:0] SCAN_HI   = BW'(bpa_pkg::LAST_BITS - 1);
  localparam logic [PW-1:0] PAGE_LIM  = PW'(bpa_pkg::NUM_PAGES);

  bpa_pkg::state_t   state_r, state_nxt;
  bpa_pkg::word_op_t op_r, op_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic              resp_clr_r, resp_clr_nxt;
  logic [PW-1:0]     free_pages_r, free_pages_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     w_r, w_nxt;
  logic [IW-1:0]     first_w_r, first_w_nxt;
  logic [IW-1:0]     last_w_r, last_w_nxt;
  logic [BW-1:0]     lo_r, lo_nxt;
  logic [BW-1:0]     hi_r, hi_nxt;
  logic [IW-1:0]     scan_w_r, scan_w_nxt;
  logic [IW-1:0]     chk_w_r, chk_w_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [AW-1:0]     page_addr_r, page_addr_nxt;
  logic [SW-1:0]     status_r, status_nxt;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WB-1:0]     ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [WB-1:0]     ram_rdata;

  bpa_pkg::word_req_t wreq;
  bpa_pkg::word_rsp_t wrsp;

  logic [PW-1:0]     end_c;
  logic [PW-1:0]     last_page;
  logic [AW-1:0]     free_pg;
  logic              free_bad;
  logic [AW-1:0]     found_addr;

  bpa_ram #(
    .DEPTH (bpa_pkg::WORD_COUNT),
    .WIDTH (WB)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_word_unit u_word (
    .req (wreq),
    .rsp (wrsp)
  );

  always_comb begin
    end_c     = (in_item.end_page > PAGE_LIM) ? PAGE_LIM : in_item.end_page;
    last_page = end_c - PW'(1);
    free_pg   = in_item.address >> PS;
    free_bad  = (|in_item.address[PS-1:0]) || (free_pg >= AW'(bpa_pkg::NUM_PAGES));
    found_addr = AW'({chk_w_r, wrsp.find_bit}) << PS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bpa_pkg::ST_CLEAR;
      clr_r        <= '0;
      resp_clr_r   <= 1'b0;
      free_pages_r <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      resp_clr_r   <= resp_clr_nxt;
      free_pages_r <= free_pages_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cnt_r       <= cnt_nxt;
    w_r         <= w_nxt;
    first_w_r   <= first_w_nxt;
    last_w_r    <= last_w_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    scan_w_r    <= scan_w_nxt;
    chk_w_r     <= chk_w_nxt;
    chk_valid_r <= chk_valid_nxt;
    page_addr_r <= page_addr_nxt;
    status_r    <= status_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    clr_nxt       = clr_r;
    resp_clr_nxt  = resp_clr_r;
    pend_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    first_w_nxt   = first_w_r;
    last_w_nxt    = last_w_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    scan_w_nxt    = scan_w_r;
    chk_w_nxt     = chk_w_r;
    chk_valid_nxt = chk_valid_r;
    page_addr_nxt = page_addr_r;
    status_nxt    = status_r;

    // count change from the previous range word is applied in the following cycle, via pend_r
    free_pages_nxt = free_pages_r;
    if (pend_r) begin
      if (op_r == bpa_pkg::OP_RELEASE) begin
        free_pages_nxt = free_pages_r + PW'(cnt_r);
      end else begin
        free_pages_nxt = free_pages_r - PW'(cnt_r);
      end
    end

    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = wrsp.new_word;
    ram_raddr = w_r;

    wreq.op       = op_r;
    wreq.old_word = ram_rdata;
    wreq.lo       = lo_r;
    wreq.hi       = hi_r;

    case (state_r)
      bpa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '1;
        if (clr_r == LAST_WORD) begin
          state_nxt = resp_clr_r ? bpa_pkg::ST_RESP : bpa_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end

      bpa_pkg::ST_IDLE: begin
        if (start) begin
          status_nxt    = bpa_pkg::STAT_DONE;
          page_addr_nxt = '0;
          case (in_item.action)
            bpa_pkg::ACT_RESERVE_ALL: begin
              clr_nxt        = '0;
              free_pages_nxt = '0;
              resp_clr_nxt   = 1'b1;
              state_nxt      = bpa_pkg::ST_CLEAR;
            end
            bpa_pkg::ACT_RELEASE_RANGE, bpa_pkg::ACT_RESERVE_RANGE: begin
              op_nxt = (in_item.action == bpa_pkg::ACT_RELEASE_RANGE) ?
                       bpa_pkg::OP_RELEASE : bpa_pkg::OP_RESERVE;
              first_w_nxt = in_item.first_page[BW +: IW];
              w_nxt       = in_item.first_page[BW +: IW];
              last_w_nxt  = last_page[BW +: IW];
              lo_nxt      = in_item.first_page[BW-1:0];
              hi_nxt      = last_page[BW-1:0];
              if (in_item.first_page < end_c) begin
                state_nxt = bpa_pkg::ST_RANGE_RD;
              end else begin
                state_nxt = bpa_pkg::ST_RESP;
              end
            end
            bpa_pkg::ACT_ALLOCATE: begin
              op_nxt        = bpa_pkg::OP_ALLOC;
              scan_w_nxt    = '0;
              chk_valid_nxt = 1'b0;
              state_nxt     = bpa_pkg::ST_SCAN;
            end
            bpa_pkg::ACT_FREE_ADDRESS: begin
              op_nxt = bpa_pkg::OP_RELEASE;
              w_nxt  = in_item.address[PS + BW +: IW];
              lo_nxt = in_item.address[PS +: BW];
              hi_nxt = in_item.address[PS +: BW];
              if (free_bad) begin
                status_nxt = bpa_pkg::STAT_REJECTED;
                state_nxt  = bpa_pkg::ST_RESP;
              end else begin
                state_nxt = bpa_pkg::ST_FREE_RD;
              end
            end
            default: begin
              state_nxt = bpa_pkg::ST_RESP;
            end
          endcase
        end
      end

      bpa_pkg::ST_RANGE_RD: begin
        state_nxt = bpa_pkg::ST_RANGE_WR;
      end

      bpa_pkg::ST_RANGE_WR: begin
        wreq.lo  = (w_r == first_w_r) ? lo_r : '0;
        wreq.hi  = (w_r == last_w_r) ? hi_r : '1;
        ram_we   = 1'b1;
        cnt_nxt  = wrsp.cnt;
        pend_nxt = 1'b1;
        if (w_r == last_w_r) begin
          state_nxt = bpa_pkg::ST_FIN;
        end else begin
          w_nxt     = w_r + IW'(1);
          ram_raddr = w_r + IW'(1);
          state_nxt = bpa_pkg::ST_RANGE_RD;
        end
      end

      bpa_pkg::ST_FIN: begin
        state_nxt = bpa_pkg::ST_RESP;
      end

      bpa_pkg::ST_SCAN: begin
        // reads run one word ahead of the check; page 0 is never handed out
        ram_raddr     = scan_w_r;
        chk_w_nxt     = scan_w_r;
        chk_valid_nxt = 1'b1;
        if (scan_w_r != SCAN_LAST) begin
          scan_w_nxt = scan_w_r + IW'(1);
        end
        wreq.lo = (chk_w_r == '0) ? BW'(1) : '0;
        wreq.hi = (chk_w_r == SCAN_LAST) ? SCAN_HI : '1;
        if (chk_valid_r) begin
          if (wrsp.found) begin
            ram_we         = 1'b1;
            ram_waddr      = chk_w_r;
            free_pages_nxt = free_pages_r - PW'(1);
            page_addr_nxt  = found_addr;
            state_nxt      = bpa_pkg::ST_RESP;
          end else if (chk_w_r == SCAN_LAST) begin
            status_nxt = bpa_pkg::STAT_NO_FREE;
            state_nxt  = bpa_pkg::ST_RESP;
          end
        end
      end

      bpa_pkg::ST_FREE_RD: begin
        state_nxt = bpa_pkg::ST_FREE_WR;
      end

      bpa_pkg::ST_FREE_WR: begin
        if (wrsp.found) begin
          ram_we         = 1'b1;
          free_pages_nxt = free_pages_r + PW'(1);
        end else begin
          status_nxt = bpa_pkg::STAT_ALREADY_FREE;
        end
        state_nxt = bpa_pkg::ST_RESP;
      end

      bpa_pkg::ST_RESP: begin
        resp_clr_nxt = 1'b0;
        state_nxt    = bpa_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != bpa_pkg::ST_IDLE);
  assign out_strobe = (state_r == bpa_pkg::ST_RESP);

  always_comb begin
    out_item.page_address = page_addr_r;
    out_item.status       = status_r;
    out_item.free_count   = free_pages_r;
  end

endmodule
`default_nettype wire

// File: dv/bpa_result_checker.sv
`timescale 1ns / 1ps
module bpa_result_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire bpa_pkg::in_item_t  in_item,
  input  wire logic               out_strobe,
  input  wire bpa_pkg::out_item_t out_item,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen,
  output int                      alloc_misses
);
  import bpa_pkg::*;

  // shadow bitmap, one bit per page frame, 1 = used
  bit [WORD_BITS-1:0] page_words [WORD_COUNT];
  int unsigned        free_total;
  out_item_t          expected_q [$];

  int n_fail    = 0;
  int n_pending = 0;
  int n_seen    = 0;
  int n_miss    = 0;

  assign fail_count   = n_fail;
  assign pending      = n_pending;
  assign results_seen = n_seen;
  assign alloc_misses = n_miss;

  task automatic report_error(string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    n_fail++;
  endtask

  function automatic bit page_used(int unsigned pg);
    return page_words[pg / WORD_BITS][pg % WORD_BITS];
  endfunction

  function automatic void mark_page(int unsigned pg, bit used);
    page_words[pg / WORD_BITS][pg % WORD_BITS] = used;
  endfunction

  function automatic void reserve_everything();
    foreach (page_words[w]) page_words[w] = '1;
    free_total = 0;
  endfunction

  function automatic void walk_range(int unsigned first, int unsigned stop, bit freeing);
    int unsigned last_excl;
    last_excl = (stop > NUM_PAGES) ? NUM_PAGES : stop;
    for (int unsigned p = first; p < last_excl; p++) begin
      if (freeing && page_used(p)) begin
        mark_page(p, 1'b0);
        free_total++;
      end else if (!freeing && !page_used(p)) begin
        mark_page(p, 1'b1);
        free_total--;
      end
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t   res;
    int unsigned pg;
    bit          hit;
    res = '0;
    res.status = STAT_DONE;
    case (it.action)
      ACT_RESERVE_ALL: begin
        reserve_everything();
      end
      ACT_RELEASE_RANGE: begin
        walk_range(32'(it.first_page), 32'(it.end_page), 1'b1);
      end
      ACT_RESERVE_RANGE: begin
        walk_range(32'(it.first_page), 32'(it.end_page), 1'b0);
      end
      ACT_ALLOCATE: begin
        // first fit from page 1, skipping full words
        hit = 1'b0;
        for (int unsigned w = 0; w < SCAN_WORDS && !hit; w++) begin
          if (page_words[w] != '1) begin
            for (int unsigned b = 0; b < WORD_BITS && !hit; b++) begin
              pg = w * WORD_BITS + b;
              if (pg >= 1 && pg < LIMIT_PAGES && !page_words[w][b]) begin
                mark_page(pg, 1'b1);
                free_total--;
                res.page_address = pg << PAGE_SHIFT;
                hit = 1'b1;
              end
            end
          end
        end
        if (!hit) res.status = STAT_NO_FREE;
      end
      ACT_FREE_ADDRESS: begin
        pg = it.address >> PAGE_SHIFT;
        if (it.address[PAGE_SHIFT-1:0] != '0 || pg >= NUM_PAGES) begin
          res.status = STAT_REJECTED;
        end else if (!page_used(pg)) begin
          res.status = STAT_ALREADY_FREE;
        end else begin
          mark_page(pg, 1'b0);
          free_total++;
        end
      end
      default: ;
    endcase
    res.free_count = free_total[PAGE_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      reserve_everything();
      expected_q.delete();
    end else begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result with none outstanding: addr %0h status %0d count %0d",
                                 out_item.page_address, out_item.status, out_item.free_count));
        end else begin
          want = expected_q.pop_front();
          n_seen++;
          if (want.status == STAT_NO_FREE) n_miss++;
          if (out_item.page_address !== want.page_address)
            report_error($sformatf("page_address %0h, expected %0h",
                                   out_item.page_address, want.page_address));
          if (out_item.status !== want.status)
            report_error($sformatf("status %0d, expected %0d", out_item.status, want.status));
          if (out_item.free_count !== want.free_count)
            report_error($sformatf("free_count %0d, expected %0d",
                                   out_item.free_count, want.free_count));
        end
      end
      if (start && !busy) expected_q.push_back(predict_result(in_item));
    end
    n_pending = expected_q.size();
  end

endmodule

// File: dv/bitmap_page_allocator_core_tb.sv
`timescale 1ns / 1ps
module bitmap_page_allocator_core_tb;
  import bpa_pkg::*;

  localparam int unsigned PAGE_MAX   = (1 << PAGE_W) - 1;
  localparam int unsigned OFFSET_MAX = (1 << PAGE_SHIFT) - 1;
  localparam int          RANDOM_CNT = 1575;
  localparam int          DRAIN_MAX  = 20000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  int fail_count;
  int pending;
  int results_seen;
  int alloc_misses;

  int sent_by_action [ACT_FREE_ADDRESS + 1];
  int sent_unknown = 0;
  int burst_left   = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  bitmap_page_allocator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  bpa_result_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_strobe   (out_strobe),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .alloc_misses (alloc_misses)
  );

  function automatic in_item_t make_item(logic [ACTION_W-1:0] act, int unsigned first,
                                         int unsigned stop, logic [ADDR_W-1:0] addr);
    in_item_t it;
    it.action     = act;
    it.first_page = first[PAGE_W-1:0];
    it.end_page   = stop[PAGE_W-1:0];
    it.address    = addr;
    return it;
  endfunction

  function automatic int unsigned any_page();
    return $urandom_range(0, PAGE_MAX);
  endfunction

  // mostly short ranges low in memory so allocation scans stay short
  function automatic in_item_t range_request(logic [ACTION_W-1:0] act);
    int unsigned sel;
    int unsigned first;
    int unsigned stop;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      first = $urandom_range(0, 4095);
      stop  = first + $urandom_range(0, 40);
    end else if (sel < 93) begin
      first = any_page();
      stop  = first + $urandom_range(0, 64);
    end else if (sel < 98) begin
      stop  = any_page();
      first = stop + $urandom_range(1, 64);
    end else begin
      first = any_page();
      stop  = any_page();
    end
    return make_item(act, first, stop, $urandom);
  endfunction

  function automatic in_item_t random_request();
    int unsigned       sel;
    int unsigned       sub;
    logic [ADDR_W-1:0] addr;
    sel = $urandom_range(0, 999);
    if (sel < 330 || sel >= 960) begin
      return make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom);
    end else if (sel < 530) begin
      sub = $urandom_range(0, 9);
      if (sub < 7)
        addr = $urandom_range(0, 4095) << PAGE_SHIFT;
      else if (sub == 7)
        addr = $urandom_range(0, NUM_PAGES - 1) << PAGE_SHIFT;
      else if (sub == 8)
        addr = ($urandom_range(0, 4095) << PAGE_SHIFT) | $urandom_range(1, OFFSET_MAX);
      else
        addr = $urandom;
      return make_item(ACT_FREE_ADDRESS, any_page(), any_page(), addr);
    end else if (sel < 740) begin
      return range_request(ACT_RELEASE_RANGE);
    end else if (sel < 920) begin
      return range_request(ACT_RESERVE_RANGE);
    end else if (sel < 930) begin
      return make_item(ACT_RESERVE_ALL, any_page(), any_page(), $urandom);
    end
    return make_item(ACTION_W'(ACT_FREE_ADDRESS + 1 + $urandom_range(0, 2)), any_page(),
                     any_page(), $urandom);
  endfunction

  // hold start until the block takes the transaction, then maybe idle
  task automatic send(in_item_t it);
    int unsigned sel;
    int unsigned gap;
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.action > ACT_FREE_ADDRESS) sent_unknown++;
    else sent_by_action[it.action]++;

    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 8) burst_left = $urandom_range(10, 40);
      else if (sel < 60) gap = $urandom_range(0, 3);
      else if (sel < 92) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      start   <= 1'b0;
      in_item <= make_item(ACTION_W'($urandom), any_page(), any_page(), $urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int waited;
    foreach (sent_by_action[a]) sent_by_action[a] = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // everything used after reset; page zero is never handed out
    send(make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom));
    send(make_item(ACT_FREE_ADDRESS, any_page(), any_page(), 32'h0000_0000));
    send(make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom));
    send(make_item(ACT_FREE_ADDRESS, any_page(), any_page(), 32'h0000_0000));
    send(make_item(ACT_RELEASE_RANGE, 0, 16, $urandom));
    send(make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom));
    // bad frees (unaligned, beyond the page count, top of the address space), then the last valid page
    send(make_item(ACT_FREE_ADDRESS, any_page(), any_page(), 32'h0000_1001));
    send(make_item(ACT_FREE_ADDRESS, any_page(), any_page(), 32'h1000_0000));
    send(make_item(ACT_FREE_ADDRESS, any_page(), any_page(), 32'hFFFF_F000));
    send(make_item(ACT_FREE_ADDRESS, any_page(), any_page(), 32'h0FFF_F000));
    // clamped and empty ranges
    send(make_item(ACT_RELEASE_RANGE, NUM_PAGES - 6, PAGE_MAX, $urandom));
    send(make_item(ACT_RELEASE_RANGE, NUM_PAGES, NUM_PAGES, $urandom));
    send(make_item(ACT_RESERVE_RANGE, 10, 5, $urandom));
    send(make_item(ACT_RESERVE_RANGE, NUM_PAGES - 1, PAGE_MAX, $urandom));
    send(make_item(ACT_RELEASE_RANGE, 0, NUM_PAGES, $urandom));
    send(make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom));
    send(make_item(ACT_RESERVE_RANGE, 0, PAGE_MAX, $urandom));
    // only the last page free: longest allocation scan
    send(make_item(ACT_RELEASE_RANGE, NUM_PAGES - 1, NUM_PAGES, $urandom));
    send(make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom));
    send(make_item(ACT_ALLOCATE, any_page(), any_page(), $urandom));
    send(make_item(ACTION_W'(ACT_FREE_ADDRESS + 1), any_page(), any_page(), $urandom));
    send(make_item(ACTION_W'(ACT_FREE_ADDRESS + 2), any_page(), any_page(), $urandom));
    send(make_item(ACTION_W'(ACT_FREE_ADDRESS + 3), any_page(), any_page(), $urandom));
    send(make_item(ACT_RELEASE_RANGE, 0, 4096, $urandom));
    send(make_item(ACT_RESERVE_ALL, any_page(), any_page(), $urandom));
    send(make_item(ACT_RELEASE_RANGE, 0, 2048, $urandom));

    for (int i = 0; i < RANDOM_CNT; i++) send(random_request());
    start <= 1'b0;

    waited = 0;
    @(negedge clk);
    while (pending != 0 && waited < DRAIN_MAX) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("%0d results never arrived", pending);
      $display("simulation failed");
    end else begin
      repeat (50) @(posedge clk);
      $display("sent %0d allocate, %0d free, %0d release, %0d reserve, %0d reserve-all, %0d other",
               sent_by_action[ACT_ALLOCATE], sent_by_action[ACT_FREE_ADDRESS],
               sent_by_action[ACT_RELEASE_RANGE], sent_by_action[ACT_RESERVE_RANGE],
               sent_by_action[ACT_RESERVE_ALL], sent_unknown);
      $display("checked %0d results, %0d allocations found no page, %0d errors",
               results_seen, alloc_misses, fail_count);
      if (fail_count == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule

// File: sim.f
src/bpa_pkg.sv
src/bpa_ram.sv
src/bpa_word_unit.sv
src/bitmap_page_allocator_core.sv
dv/bpa_result_checker.sv
dv/bitmap_page_allocator_core_tb.sv
